FILE: rtl/imu_frame_parser_yaw_unwrap_core_macros.svh
// Assertion macros shared by the IMU frame parser RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef IMU_FRAME_PARSER_YAW_UNWRAP_CORE_MACROS_SVH
`define IMU_FRAME_PARSER_YAW_UNWRAP_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define IFPYU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define IFPYU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ifpyu_pkg.sv
// Package for the IMU frame parser with yaw unwrap: widths, defaults,
// register indexes and shared types. No dependencies.
package ifpyu_pkg;

    localparam int FRAME_BYTES_DEF       = 11;
    localparam int FRAMES_PER_BUFFER_DEF = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FRAME_TYPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FRAME_TYPE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD   = 2'd3;

    localparam logic [7:0]  HEADER_BYTE_RST      = 8'd85;
    localparam logic [7:0]  RATE_FRAME_TYPE_RST  = 8'd82;
    localparam logic [7:0]  ANGLE_FRAME_TYPE_RST = 8'd83;
    localparam logic [15:0] WRAP_THRESHOLD_RST   = 16'd54613;

    localparam logic KIND_RATE  = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;

    // Request from the frame parser to the yaw unwrap unit.
    typedef struct packed {
        logic        update;
        logic [15:0] yaw_raw;
    } t_unwrap_req;

endpackage

FILE: rtl/ifpyu_ifs.sv
// Valid/ready channel interfaces: byte input, result output, config write.
// Depends on ifpyu_pkg for the config port widths.
interface ifpyu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_start;

    modport source (output valid, output data_byte, output buffer_start, input ready);
    modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface ifpyu_out_if;
    logic               valid;
    logic               ready;
    logic               frame_kind;
    logic signed [15:0] pitch_angle;
    logic signed [47:0] yaw_cont;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;

    modport source (output valid, output frame_kind, output pitch_angle, output yaw_cont,
                    output pitch_rate, output yaw_rate, input ready);
    modport sink   (input valid, input frame_kind, input pitch_angle, input yaw_cont,
                    input pitch_rate, input yaw_rate, output ready);
endinterface

interface ifpyu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ifpyu_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [ifpyu_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: rtl/ifpyu_unwrap.sv
// Yaw unwrap unit: holds the previous raw yaw and the turn count, and forms
// the continuous 48-bit yaw. Depends on ifpyu_pkg.
module ifpyu_unwrap (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ifpyu_pkg::t_unwrap_req i_req,
    input  logic [15:0]            i_threshold,
    output logic signed [47:0]     o_yaw_next
);

    logic [15:0]        r_prev_yaw;
    logic [31:0]        r_turns;
    logic [15:0]        n_prev_yaw;
    logic [31:0]        n_turns;
    logic signed [17:0] diff;
    logic signed [17:0] thr;
    logic               wrap_dec;
    logic               wrap_inc;

    always_comb begin
        diff = $signed({{2{i_req.yaw_raw[15]}}, i_req.yaw_raw})
             - $signed({{2{r_prev_yaw[15]}}, r_prev_yaw});
        thr      = $signed({2'b00, i_threshold});
        wrap_dec = i_req.update && (diff > thr);
        wrap_inc = i_req.update && (diff < -thr);

        n_turns = r_turns;
        if (wrap_dec) begin
            n_turns = r_turns - 32'd1;
        end else if (wrap_inc) begin
            n_turns = r_turns + 32'd1;
        end
        n_prev_yaw = i_req.update ? i_req.yaw_raw : r_prev_yaw;

        // raw sign-extended plus turns << 16: the low half is raw, the sign
        // of raw borrows one from the turn count.
        o_yaw_next = $signed({n_turns - {31'd0, n_prev_yaw[15]}, n_prev_yaw});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_yaw <= '0;
            r_turns    <= '0;
        end else begin
            r_prev_yaw <= n_prev_yaw;
            r_turns    <= n_turns;
        end
    end

endmodule

FILE: rtl/imu_frame_parser_yaw_unwrap_core.sv
// IMU frame parser with yaw unwrap: takes one buffer byte per transfer, cuts
// the buffer into FRAME_BYTES-byte frames (up to FRAMES_PER_BUFFER of them),
// and after each rate or angle frame sends one result with the held pitch
// and yaw rates, pitch angle and continuous 48-bit yaw. A byte is held in the
// input register while the parse logic works on it; the result register loads
// from the parse logic when the last byte of a frame leaves the input register.
// One byte is accepted every cycle; the parse stage waits only when it has a
// result to load while the previous result has not yet been taken. A header
// mismatch skips the rest of the buffer until the next byte flagged as buffer
// start.
`include "imu_frame_parser_yaw_unwrap_core_macros.svh"

module imu_frame_parser_yaw_unwrap_core #(
    parameter int FRAME_BYTES       = ifpyu_pkg::FRAME_BYTES_DEF,
    parameter int FRAMES_PER_BUFFER = ifpyu_pkg::FRAMES_PER_BUFFER_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ifpyu_in_if.sink   i_in,
    ifpyu_cfg_if.sink  i_cfg,
    ifpyu_out_if.source o_out
);

    localparam int KW = $clog2(FRAME_BYTES);
    localparam int FW = $clog2(FRAMES_PER_BUFFER + 1);
    localparam logic [KW-1:0] LAST_K     = KW'(FRAME_BYTES - 1);
    localparam logic [FW-1:0] FRAMES_END = FW'(FRAMES_PER_BUFFER);

    // configuration
    logic [7:0]  r_header;
    logic [7:0]  r_rate_type;
    logic [7:0]  r_angle_type;
    logic [15:0] r_threshold;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // parse state
    logic [KW-1:0] r_k;
    logic [FW-1:0] r_f;
    logic          r_aborted;
    logic [7:0]    r_type;
    logic [31:0]   r_field;
    logic [15:0]   r_pitch;
    logic [31:0]   r_rates;

    // result register
    logic               r_out_valid;
    logic               r_out_kind;
    logic signed [15:0] r_out_pitch;
    logic signed [47:0] r_out_yaw;
    logic [31:0]        r_out_rates;

    logic [KW-1:0] eff_k;
    logic [FW-1:0] eff_f;
    logic          eff_ab;
    logic          active;
    logic          last;
    logic          is_rate;
    logic          is_angle;
    logic          produce;
    logic          adv;
    logic          fire;
    logic [KW-1:0] n_k;
    logic [FW-1:0] n_f;
    logic          n_aborted;
    logic [7:0]    n_type;
    logic [31:0]   n_field;
    logic [15:0]   n_pitch;
    logic [31:0]   n_rates;
    logic signed [47:0]     yaw_next;
    ifpyu_pkg::t_unwrap_req unwrap_req;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header     <= ifpyu_pkg::HEADER_BYTE_RST;
            r_rate_type  <= ifpyu_pkg::RATE_FRAME_TYPE_RST;
            r_angle_type <= ifpyu_pkg::ANGLE_FRAME_TYPE_RST;
            r_threshold  <= ifpyu_pkg::WRAP_THRESHOLD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                ifpyu_pkg::CFG_HEADER_BYTE:      r_header     <= i_cfg.wr_data[7:0];
                ifpyu_pkg::CFG_RATE_FRAME_TYPE:  r_rate_type  <= i_cfg.wr_data[7:0];
                ifpyu_pkg::CFG_ANGLE_FRAME_TYPE: r_angle_type <= i_cfg.wr_data[7:0];
                ifpyu_pkg::CFG_WRAP_THRESHOLD:   r_threshold  <= i_cfg.wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // a buffer start restarts position and clears the abort
        eff_k  = r_in_start ? '0 : r_k;
        eff_f  = r_in_start ? '0 : r_f;
        eff_ab = r_in_start ? 1'b0 : r_aborted;
        active = r_in_valid && !eff_ab && (eff_f != FRAMES_END);
        last   = active && (eff_k == LAST_K);

        n_type  = r_type;
        n_field = r_field;
        n_aborted = eff_ab;
        if (active) begin
            case (eff_k)
                KW'(0): n_aborted = (r_in_byte != r_header);
                KW'(1): n_type = r_in_byte;
                KW'(2): n_field[7:0]   = r_in_byte;
                KW'(3): n_field[15:8]  = r_in_byte;
                KW'(6): n_field[23:16] = r_in_byte;
                KW'(7): n_field[31:24] = r_in_byte;
                default: ;
            endcase
        end

        if (active) begin
            n_k = (eff_k == LAST_K) ? '0 : eff_k + KW'(1);
            n_f = (eff_k == LAST_K) ? eff_f + FW'(1) : eff_f;
        end else begin
            n_k = eff_k;
            n_f = eff_f;
        end

        is_rate  = (n_type == r_rate_type);
        is_angle = !is_rate && (n_type == r_angle_type);
        produce  = last && (is_rate || is_angle);

        adv  = !r_in_valid || !produce || !r_out_valid || o_out.ready;
        fire = r_in_valid && adv;

        n_pitch = (produce && is_angle) ? n_field[15:0] : r_pitch;
        n_rates = (produce && is_rate) ? n_field : r_rates;

        unwrap_req.update  = fire && produce && is_angle;
        unwrap_req.yaw_raw = n_field[31:16];
    end

    assign i_in.ready = adv;

    ifpyu_unwrap u_unwrap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (unwrap_req),
        .i_threshold (r_threshold),
        .o_yaw_next  (yaw_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_in_byte  <= i_in.data_byte;
            r_in_start <= i_in.buffer_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_f       <= '0;
            r_aborted <= 1'b0;
            r_type    <= '0;
            r_field   <= '0;
            r_pitch   <= '0;
            r_rates   <= '0;
        end else if (fire) begin
            r_k       <= n_k;
            r_f       <= n_f;
            r_aborted <= n_aborted;
            r_type    <= n_type;
            r_field   <= n_field;
            r_pitch   <= n_pitch;
            r_rates   <= n_rates;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && produce) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && produce) begin
            r_out_kind  <= is_angle ? ifpyu_pkg::KIND_ANGLE : ifpyu_pkg::KIND_RATE;
            r_out_pitch <= $signed(n_pitch);
            r_out_yaw   <= yaw_next;
            r_out_rates <= n_rates;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.frame_kind  = r_out_kind;
    assign o_out.pitch_angle = r_out_pitch;
    assign o_out.yaw_cont    = r_out_yaw;
    assign o_out.pitch_rate  = $signed(r_out_rates[15:0]);
    assign o_out.yaw_rate    = $signed(r_out_rates[31:16]);

    `IFPYU_ASSERT_ALWAYS(a_frame_bound, i_clk, i_rst_n, r_f <= FRAMES_END, "frame count past end")
    `IFPYU_ASSERT_ALWAYS(a_byte_bound, i_clk, i_rst_n, r_k <= LAST_K, "byte index past frame")
    `IFPYU_ASSERT_ALWAYS(a_saturated, i_clk, i_rst_n, (r_f != FRAMES_END) || (r_k == '0), "bad stop")
    `IFPYU_ASSERT_NEXT(a_result_load, i_clk, i_rst_n, fire && produce, r_out_valid, "result not loaded")
    `IFPYU_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_in_byte) && $stable(r_in_start), "stalled byte lost")

endmodule

FILE: verif/ifpyu_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the IMU frame parser: watches the byte, config and result channels,
// predicts each result from the accepted bytes and compares it field by field.
// Depends on ifpyu_pkg and the channel interfaces in ifpyu_ifs.sv.
module ifpyu_frame_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ifpyu_in_if   i_in,
    ifpyu_cfg_if  i_cfg,
    ifpyu_out_if  i_out,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int FRAME_LEN = ifpyu_pkg::FRAME_BYTES_DEF;
    localparam int BUF_BYTES = ifpyu_pkg::FRAME_BYTES_DEF * ifpyu_pkg::FRAMES_PER_BUFFER_DEF;

    localparam int SLOT_HEADER = 0;
    localparam int SLOT_TYPE   = 1;
    localparam int SLOT_X_LO   = 2;
    localparam int SLOT_X_HI   = 3;
    localparam int SLOT_Z_LO   = 6;
    localparam int SLOT_Z_HI   = 7;

    typedef struct packed {
        logic        kind;
        logic [15:0] pitch;
        logic [47:0] yaw;
        logic [15:0] pitch_rate;
        logic [15:0] yaw_rate;
    } t_imu_sample;

    // register copies
    logic [7:0]  hdr_reg;
    logic [7:0]  rate_type_reg;
    logic [7:0]  angle_type_reg;
    logic [15:0] wrap_thr_reg;

    // parser and unwrap state
    logic [5:0]  byte_pos;
    logic        skip_rest;
    logic [7:0]  cur_type;
    logic [31:0] field_word;    // x lo, x hi, z lo, z hi
    logic [15:0] last_yaw;
    logic [31:0] turns;
    logic [15:0] pitch_hold;
    logic [31:0] rates_hold;    // pitch rate low half, yaw rate high half

    t_imu_sample expected_samples[$];
    int          errors = 0;

    task automatic flag_error(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [47:0] got,
                                 input logic [47:0] want);
        if (got !== want)
            flag_error($sformatf("%s mismatch: got %h, expected %h", name, got, want));
    endtask

    task automatic reset_model();
        hdr_reg        = ifpyu_pkg::HEADER_BYTE_RST;
        rate_type_reg  = ifpyu_pkg::RATE_FRAME_TYPE_RST;
        angle_type_reg = ifpyu_pkg::ANGLE_FRAME_TYPE_RST;
        wrap_thr_reg   = ifpyu_pkg::WRAP_THRESHOLD_RST;
        byte_pos       = '0;
        skip_rest      = 1'b0;
        cur_type       = '0;
        field_word     = '0;
        last_yaw       = '0;
        turns          = '0;
        pitch_hold     = '0;
        rates_hold     = '0;
        expected_samples.delete();
    endtask

    task automatic write_model_reg(input logic [ifpyu_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [ifpyu_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            ifpyu_pkg::CFG_HEADER_BYTE:      hdr_reg        = val[7:0];
            ifpyu_pkg::CFG_RATE_FRAME_TYPE:  rate_type_reg  = val[7:0];
            ifpyu_pkg::CFG_ANGLE_FRAME_TYPE: angle_type_reg = val[7:0];
            ifpyu_pkg::CFG_WRAP_THRESHOLD:   wrap_thr_reg   = val;
            default: ;
        endcase
    endtask

    // Advance the parser by one byte; queue a sample when a rate or angle frame ends.
    task automatic parse_byte(input logic [7:0] b, input logic start);
        int          slot;
        int          yaw_step;
        int          thr;
        logic [15:0] z;
        t_imu_sample s;
        if (start) begin
            byte_pos  = '0;
            skip_rest = 1'b0;
        end
        if (skip_rest || byte_pos >= BUF_BYTES)
            return;
        slot     = byte_pos % FRAME_LEN;
        byte_pos = byte_pos + 6'd1;
        case (slot)
            SLOT_HEADER: if (b != hdr_reg) skip_rest = 1'b1;
            SLOT_TYPE:   cur_type = b;
            SLOT_X_LO:   field_word[7:0]   = b;
            SLOT_X_HI:   field_word[15:8]  = b;
            SLOT_Z_LO:   field_word[23:16] = b;
            SLOT_Z_HI:   field_word[31:24] = b;
            default: ;
        endcase
        if (slot != FRAME_LEN - 1)
            return;

        // rate type wins when both type registers match
        if (cur_type == rate_type_reg) begin
            rates_hold = field_word;
            s.kind     = ifpyu_pkg::KIND_RATE;
        end else if (cur_type == angle_type_reg) begin
            z          = field_word[31:16];
            yaw_step   = int'($signed(z)) - int'($signed(last_yaw));
            thr        = int'(wrap_thr_reg);
            pitch_hold = field_word[15:0];
            if (yaw_step > thr)
                turns = turns - 32'd1;
            if (yaw_step < -thr)
                turns = turns + 32'd1;
            last_yaw = z;
            s.kind   = ifpyu_pkg::KIND_ANGLE;
        end else begin
            return;
        end
        s.pitch      = pitch_hold;
        s.yaw        = {{32{last_yaw[15]}}, last_yaw} + {turns, 16'h0000};
        s.pitch_rate = rates_hold[15:0];
        s.yaw_rate   = rates_hold[31:16];
        expected_samples.push_back(s);
    endtask

    always @(posedge i_clk) begin
        t_imu_sample want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                write_model_reg(i_cfg.reg_index, i_cfg.wr_data);
            if (i_out.valid && i_out.ready) begin
                if (expected_samples.size() == 0) begin
                    flag_error($sformatf("unexpected result: kind %0d pitch %0d yaw %0d",
                                         i_out.frame_kind, i_out.pitch_angle,
                                         i_out.yaw_cont));
                end else begin
                    want = expected_samples.pop_front();
                    compare_field("frame_kind", {47'h0, i_out.frame_kind}, {47'h0, want.kind});
                    compare_field("pitch_angle", {32'h0, i_out.pitch_angle},
                                  {32'h0, want.pitch});
                    compare_field("yaw_cont", i_out.yaw_cont, want.yaw);
                    compare_field("pitch_rate", {32'h0, i_out.pitch_rate},
                                  {32'h0, want.pitch_rate});
                    compare_field("yaw_rate", {32'h0, i_out.yaw_rate},
                                  {32'h0, want.yaw_rate});
                end
            end
            if (i_in.valid && i_in.ready)
                parse_byte(i_in.data_byte, i_in.buffer_start);
        end
        o_pending    <= expected_samples.size();
        o_fail_count <= errors;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Top of the IMU frame parser testbench: clock, reset, byte and register stimulus,
// result-side back-pressure and the verdict. Depends on ifpyu_pkg, ifpyu_ifs.sv,
// ifpyu_frame_checker and imu_frame_parser_yaw_unwrap_core.
module tb;

    localparam int FRAME_LEN = ifpyu_pkg::FRAME_BYTES_DEF;
    localparam int BUF_BYTES = ifpyu_pkg::FRAME_BYTES_DEF * ifpyu_pkg::FRAMES_PER_BUFFER_DEF;

    localparam int SLOT_HEADER = 0;
    localparam int SLOT_TYPE   = 1;
    localparam int SLOT_Z_HI   = 7;

    localparam logic [7:0] QUAT_FRAME_TYPE = 8'h59;
    localparam int         SINK_HOLD_CYCLES = 90;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    ifpyu_in_if  in_ch ();
    ifpyu_cfg_if cfg_ch ();
    ifpyu_out_if out_ch ();

    int fail_count;
    int pending;

    imu_frame_parser_yaw_unwrap_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    ifpyu_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    bit         src_fast      = 1'b0;
    bit         sink_fast     = 1'b0;
    bit         sink_hold_req = 1'b0;
    int         sent_items    = 0;
    logic [7:0] hdr_now       = ifpyu_pkg::HEADER_BYTE_RST;
    logic [7:0] rate_now      = ifpyu_pkg::RATE_FRAME_TYPE_RST;
    logic [7:0] ang_type_now  = ifpyu_pkg::ANGLE_FRAME_TYPE_RST;

    // Directed buffer: rate then angle frame without a start flag, then a bad header.
    localparam logic [7:0] DIRECTED_BYTES [25] = '{
        8'h55, 8'h52, 8'h00, 8'h80, 8'hAA, 8'h55, 8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h5A,
        8'h55, 8'h53, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF,
        8'hAA, 8'h55, 8'h53
    };
    localparam int DIRECTED_RESTART = 22;

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.buffer_start <= start;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_items++;
    endtask

    // Stop offering bytes and wait until every predicted result has been taken.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // a frame with no result may still be in the pipe
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] hdr, input logic [7:0] rate_t,
                                input logic [7:0] angle_t, input logic [15:0] thr);
        logic [ifpyu_pkg::CFG_DATA_W-1:0] vals [4];
        logic [ifpyu_pkg::CFG_IDX_W-1:0]  idxs [4];
        idxs = '{ifpyu_pkg::CFG_HEADER_BYTE, ifpyu_pkg::CFG_RATE_FRAME_TYPE,
                 ifpyu_pkg::CFG_ANGLE_FRAME_TYPE, ifpyu_pkg::CFG_WRAP_THRESHOLD};
        // upper bits of the byte-wide registers carry junk
        vals = '{{8'($urandom_range(0, 255)), hdr}, {8'($urandom_range(0, 255)), rate_t},
                 {8'($urandom_range(0, 255)), angle_t}, thr};
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid     <= 1'b1;
            cfg_ch.reg_index <= idxs[i];
            cfg_ch.wr_data   <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        hdr_now      = hdr;
        rate_now     = rate_t;
        ang_type_now = angle_t;
    endtask

    // Mostly well-formed buffers; some cut short, some overrun, some with bad headers.
    task automatic send_buffer();
        int         nbytes;
        int         pick;
        logic [7:0] b;
        logic       st;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            nbytes = BUF_BYTES;
        else if (pick < 8)
            nbytes = $urandom_range(1, BUF_BYTES - 1);
        else
            nbytes = BUF_BYTES + $urandom_range(1, 8);
        for (int i = 0; i < nbytes; i++) begin
            b = 8'($urandom_range(0, 255));
            case (i % FRAME_LEN)
                SLOT_HEADER: if ($urandom_range(0, 11) != 0) b = hdr_now;
                SLOT_TYPE: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        b = rate_now;
                    else if (pick < 8)
                        b = ang_type_now;
                    else if (pick == 8)
                        b = QUAT_FRAME_TYPE;
                end
                SLOT_Z_HI: begin
                    // push yaw toward the extremes so jumps cross the threshold
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        b = 8'h7F;
                    else if (pick == 1)
                        b = 8'h80;
                end
                default: ;
            endcase
            st = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
            send_byte(b, st);
        end
    endtask

    task automatic run_phase(input int n_items);
        int goal;
        goal = sent_items + n_items;
        while (sent_items < goal) begin
            src_fast  = ($urandom_range(0, 4) == 0);
            sink_fast = ($urandom_range(0, 4) == 0);
            send_buffer();
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int n;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            n = sink_fast ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.buffer_start = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = '0;
        cfg_ch.wr_data     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 25; i++)
            send_byte(DIRECTED_BYTES[i], i == DIRECTED_RESTART);
        wait_drained();

        // long result hold-off while bytes keep coming
        src_fast      = 1'b1;
        sink_fast     = 1'b0;
        sink_hold_req = 1'b1;
        send_buffer();
        send_buffer();
        src_fast = 1'b0;
        wait_drained();
        run_phase(80);

        wait_drained();
        program_regs(8'h00, 8'hFF, 8'h00, 16'h0000);
        run_phase(80);

        wait_drained();
        program_regs(8'hFF, 8'h5A, 8'h5A, 16'hFFFF);
        run_phase(80);

        wait_drained();
        program_regs(ifpyu_pkg::HEADER_BYTE_RST, ifpyu_pkg::RATE_FRAME_TYPE_RST,
                     ifpyu_pkg::ANGLE_FRAME_TYPE_RST, 16'd30000);
        run_phase(80);

        wait_drained();
        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        run_phase(80);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
